/* rtl/ldg_pkg.sv */
// ----------------------------------------------------------------------------
// ldg_pkg
// Shared constants, types and helpers for the low-bit dequant GEMV row block.
// ----------------------------------------------------------------------------
package ldg_pkg;

  localparam int ACC_WIDTH = 48;

  localparam int CODE_W  = 8;
  localparam int CB_W    = 4;
  localparam int SCALE_W = 16;
  localparam int ZP_W    = 10;
  localparam int X_W     = 16;
  localparam int BIAS_W  = 32;
  localparam int Y_W     = 32;
  localparam int FRAC_W  = 12;

  // code - zero_point spans -511..767
  localparam int DIFF_W  = 11;
  // (code - zp) * scale fits in 28 bits signed; scale gets a zero sign bit
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = SCALE_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W + 1;
  localparam int TERM_W  = RND_W - FRAC_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_CODE_BITS = 1'b0;
  localparam logic REG_BIAS_EN   = 1'b1;

  localparam logic [CB_W-1:0] CODE_BITS_RST = CB_W'(4);

  typedef struct packed {
    logic acc_en;
    logic row_start;
    logic row_end;
  } acc_ctrl_t;

  function automatic logic [CODE_W-1:0] code_mask(input logic [CB_W-1:0] cb);
    logic [CB_W-1:0]  n;
    logic [CODE_W:0]  m;
    n = (cb > CB_W'(CODE_W)) ? CB_W'(CODE_W) : cb;
    m = ((CODE_W+1)'(1) << n) - (CODE_W+1)'(1);
    return m[CODE_W-1:0];
  endfunction

endpackage

/* rtl/ldg_cfg.sv */
// ----------------------------------------------------------------------------
// ldg_cfg
// APB register file: code width and bias enable.
// ----------------------------------------------------------------------------
module ldg_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ldg_pkg::PADDR_W-1:0]  paddr,
  input  logic [ldg_pkg::PDATA_W-1:0]  pwdata,
  output logic [ldg_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [ldg_pkg::CB_W-1:0]     code_bits_o,
  output logic                         bias_en_o
);
  import ldg_pkg::*;

  logic [CB_W-1:0] code_bits_q;
  logic            bias_en_q;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= CODE_BITS_RST;
      bias_en_q   <= 1'b1;
    end else if (wr) begin
      if (paddr[2] == REG_CODE_BITS) begin
        code_bits_q <= pwdata[CB_W-1:0];
      end else begin
        bias_en_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BIAS_EN) begin
      prdata = {{(PDATA_W-1){1'b0}}, bias_en_q};
    end else begin
      prdata = {{(PDATA_W-CB_W){1'b0}}, code_bits_q};
    end
  end

  assign code_bits_o = code_bits_q;
  assign bias_en_o   = bias_en_q;

endmodule

/* rtl/ldg_mul.sv */
// ----------------------------------------------------------------------------
// ldg_mul
// Shared signed multiplier with registered product, used twice per element.
// ----------------------------------------------------------------------------
module ldg_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [ldg_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [ldg_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [ldg_pkg::PROD_W-1:0]   p_o
);
  import ldg_pkg::*;

  logic signed [PROD_W-1:0] p_q;
  logic signed [PROD_W-1:0] p_d;

  assign p_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/ldg_acc.sv */
// ----------------------------------------------------------------------------
// ldg_acc
// Row accumulator with saturating add, 32-bit clip and output register.
// ----------------------------------------------------------------------------
module ldg_acc (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ldg_pkg::acc_ctrl_t                 ctrl_i,
  input  logic                               bias_en_i,
  input  logic signed [ldg_pkg::BIAS_W-1:0]  bias_i,
  input  logic signed [ldg_pkg::TERM_W-1:0]  term_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic signed [ldg_pkg::Y_W-1:0]     y_value_o,
  output logic                               saturated_o,
  output logic                               hold_o
);
  import ldg_pkg::*;

  localparam int SUM_W = ACC_WIDTH + 1;
  localparam int HI_W  = ACC_WIDTH - Y_W + 1;

  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0] base, acc_sat;
  logic signed [SUM_W-1:0]     sum;
  logic [HI_W-1:0]             hi;
  logic signed [Y_W-1:0]       y_q, y_d;
  logic                        sat_q, sat_d;
  logic                        out_valid_q, out_valid_d;

  always_comb begin
    if (ctrl_i.row_start) begin
      base = bias_en_i ? ACC_WIDTH'(bias_i) : '0;
    end else begin
      base = acc_q;
    end
    sum = SUM_W'(base) + SUM_W'(term_i);
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      acc_sat = sum[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                             : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      acc_sat = sum[ACC_WIDTH-1:0];
    end
    hi = acc_sat[ACC_WIDTH-1:Y_W-1];
    if (hi == '0 || hi == '1) begin
      y_d   = acc_sat[Y_W-1:0];
      sat_d = 1'b0;
    end else begin
      y_d   = acc_sat[ACC_WIDTH-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
      sat_d = 1'b1;
    end
  end

  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (ctrl_i.acc_en) begin
      acc_d = ctrl_i.row_end ? '0 : acc_sat;
      if (ctrl_i.row_end) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en && ctrl_i.row_end) begin
      y_q   <= y_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_value_o   = y_q;
  assign saturated_o = sat_q;
  assign hold_o      = out_valid_q & out_stall_i;

endmodule

/* rtl/lowbit_dequant_gemv_row.sv */
// ----------------------------------------------------------------------------
// lowbit_dequant_gemv_row
// Group-wise asymmetric low-bit dequant and row dot product, one shared
// multiplier under a three-state sequencer.
// ----------------------------------------------------------------------------
// A row-end request's result is registered after the second multiply (ST_MUL2)
// and the accumulate state (ST_ACC), and is delayed while a still-stalled earlier
// result holds it in accumulate. The single multiplier forms (code - zp) * scale
// and then the product with x, so no request is taken during the second multiply;
// the accumulate step overlaps the next request's first multiply.
// Reset: asynchronous, active low; accumulator cleared, code_bits 4, bias_enable 1.
// ----------------------------------------------------------------------------
module lowbit_dequant_gemv_row (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ldg_pkg::PADDR_W-1:0]         paddr,
  input  logic [ldg_pkg::PDATA_W-1:0]         pwdata,
  output logic [ldg_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ldg_pkg::CODE_W-1:0]          code_i,
  input  logic [ldg_pkg::SCALE_W-1:0]         scale_i,
  input  logic signed [ldg_pkg::ZP_W-1:0]     zero_point_i,
  input  logic signed [ldg_pkg::X_W-1:0]      x_value_i,
  input  logic signed [ldg_pkg::BIAS_W-1:0]   bias_value_i,
  input  logic                                row_start_i,
  input  logic                                row_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ldg_pkg::Y_W-1:0]      y_value_o,
  output logic                                saturated_o
);
  import ldg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL2 = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [1:0]               state_q, state_d;
  logic signed [X_W-1:0]    x_q;
  logic signed [BIAS_W-1:0] bias_q;
  logic                     row_start_q, row_end_q;

  logic [CB_W-1:0]          code_bits;
  logic                     bias_en;
  logic                     hold, blocked, ready, accept;
  logic signed [DIFF_W-1:0] diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                     mul_en;
  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0]  rnd;
  logic signed [TERM_W-1:0] term;
  acc_ctrl_t                acc_ctrl;

  ldg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .code_bits_o (code_bits),
    .bias_en_o   (bias_en)
  );

  assign blocked    = (state_q == ST_ACC) & row_end_q & hold;
  assign ready      = (state_q == ST_IDLE) | ((state_q == ST_ACC) & ~blocked);
  assign accept     = in_valid_i & ready;
  assign in_stall_o = ~ready;

  assign diff = $signed({{(DIFF_W-CODE_W){1'b0}}, code_i & code_mask(code_bits)})
              - DIFF_W'(zero_point_i);

  assign mul_a  = (state_q == ST_MUL2) ? prod[MUL_A_W-1:0] : MUL_A_W'(diff);
  assign mul_b  = (state_q == ST_MUL2) ? MUL_B_W'(x_q) : $signed({1'b0, scale_i});
  assign mul_en = accept | (state_q == ST_MUL2);

  ldg_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // round half up to 12 fraction bits
  assign rnd  = RND_W'(prod) + RND_W'(2048);
  assign term = rnd[RND_W-1:FRAC_W];

  assign acc_ctrl.acc_en    = (state_q == ST_ACC) & ~blocked;
  assign acc_ctrl.row_start = row_start_q;
  assign acc_ctrl.row_end   = row_end_q;

  ldg_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (acc_ctrl),
    .bias_en_i   (bias_en),
    .bias_i      (bias_q),
    .term_i      (term),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .y_value_o   (y_value_o),
    .saturated_o (saturated_o),
    .hold_o      (hold)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MUL2;
      end
      ST_MUL2: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (blocked) state_d = ST_ACC;
        else if (accept) state_d = ST_MUL2;
        else state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q         <= x_value_i;
      bias_q      <= bias_value_i;
      row_start_q <= row_start_i;
      row_end_q   <= row_end_i;
    end
  end

  a_accept_to_mul2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MUL2)
    else $error("accepted request did not enter second multiply");

  a_mul2_to_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL2 |=> state_q == ST_ACC)
    else $error("second multiply not followed by accumulate");

  a_result_from_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_ACC && $past(row_end_q))
    else $error("result appeared without a row-end accumulate");

  a_no_accept_in_mul2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL2 |-> !accept)
    else $error("request accepted during second multiply");

endmodule

/* bench/lowbit_dequant_gemv_row_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lowbit_dequant_gemv_row_tb
// Self-checking bench for the dequantizing row dot product. Weight requests
// go in as rows and every row result is compared with a cycle-free model of
// dequant, rounding, the saturating accumulator and the 32-bit clip. The run
// covers directed corners, random rows under several register settings and
// pacing patterns, and one long row of maximal terms that clips to 32 bits.
// ----------------------------------------------------------------------------
module lowbit_dequant_gemv_row_tb;
  import ldg_pkg::*;

  typedef struct {
    logic [CODE_W-1:0]         code;
    logic [SCALE_W-1:0]        scale;
    logic signed [ZP_W-1:0]    zero_point;
    logic signed [X_W-1:0]     x_value;
    logic signed [BIAS_W-1:0]  bias_value;
    logic                      row_start;
    logic                      row_end;
  } weight_req_t;

  typedef struct {
    logic signed [Y_W-1:0] y;
    logic                  sat;
  } row_result_t;

  localparam longint ACC_HI = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint Y_HI   = (longint'(1) <<< (Y_W - 1)) - 1;
  localparam longint Y_LO   = -Y_HI - 1;

  class row_scoreboard;
    logic [CB_W-1:0] code_bits;
    logic            bias_en;
    longint          row_acc;
    row_result_t     pending_rows[$];
    int unsigned     n_requests, n_rows, n_clipped, n_errors;

    function new();
      code_bits = CODE_BITS_RST;
      bias_en   = 1'b1;
      row_acc   = 0;
    endfunction

    function void write_reg(logic idx, logic [PDATA_W-1:0] val);
      if (idx == REG_CODE_BITS) code_bits = val[CB_W-1:0];
      else bias_en = val[0];
    endfunction

    function void note_request(weight_req_t r);
      int unsigned       width;
      logic [CODE_W-1:0] mask;
      longint            diff, term, sum;
      row_result_t       res;
      width = (code_bits > CODE_W) ? CODE_W : code_bits;
      mask  = CODE_W'((32'd1 << width) - 1);
      diff  = longint'(r.code & mask) - longint'(r.zero_point);
      // 24 fraction bits down to 12, half rounds up
      term  = (diff * longint'(r.scale) * longint'(r.x_value) + 2048) >>> FRAC_W;
      if (r.row_start) row_acc = bias_en ? longint'(r.bias_value) : 0;
      sum = row_acc + term;
      row_acc = (sum > ACC_HI) ? ACC_HI : (sum < ACC_LO) ? ACC_LO : sum;
      n_requests++;
      if (r.row_end) begin
        res.sat = (row_acc > Y_HI) || (row_acc < Y_LO);
        res.y   = (row_acc > Y_HI) ? Y_W'(Y_HI) : (row_acc < Y_LO) ? Y_W'(Y_LO)
                                    : Y_W'(row_acc);
        pending_rows.push_back(res);
        row_acc = 0;
      end
    endfunction

    function void check_result(logic signed [Y_W-1:0] y, logic sat);
      row_result_t want;
      if (pending_rows.size() == 0) begin
        $error("unexpected row result: y_value=%0d saturated=%0b", y, sat);
        n_errors++;
        return;
      end
      want = pending_rows.pop_front();
      if (y !== want.y) begin
        $error("y_value: expected %0d, got %0d", want.y, y);
        n_errors++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %0b, got %0b", want.sat, sat);
        n_errors++;
      end
      n_rows++;
      if (want.sat) n_clipped++;
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel, penable, pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [CODE_W-1:0]         code_i;
  logic [SCALE_W-1:0]        scale_i;
  logic signed [ZP_W-1:0]    zero_point_i;
  logic signed [X_W-1:0]     x_value_i;
  logic signed [BIAS_W-1:0]  bias_value_i;
  logic                      row_start_i, row_end_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [Y_W-1:0]     y_value_o;
  logic                      saturated_o;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  row_scoreboard sb = new();

  lowbit_dequant_gemv_row dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_i       (code_i),
    .scale_i      (scale_i),
    .zero_point_i (zero_point_i),
    .x_value_i    (x_value_i),
    .bias_value_i (bias_value_i),
    .row_start_i  (row_start_i),
    .row_end_i    (row_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .y_value_o    (y_value_o),
    .saturated_o  (saturated_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < snk_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(y_value_o, saturated_o);
  end

  initial begin
    #(2_000_000);
    $display("lowbit_dequant_gemv_row verification failed");
    $finish;
  end

  function automatic weight_req_t mk_req(logic [CODE_W-1:0] code,
                                         logic [SCALE_W-1:0] scale,
                                         logic signed [ZP_W-1:0] zp,
                                         logic signed [X_W-1:0] x,
                                         logic signed [BIAS_W-1:0] bias,
                                         logic s, logic e);
    weight_req_t r;
    r.code = code; r.scale = scale; r.zero_point = zp; r.x_value = x;
    r.bias_value = bias; r.row_start = s; r.row_end = e;
    return r;
  endfunction

  function automatic weight_req_t rand_req(logic s, logic e);
    weight_req_t r;
    r.code = CODE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       r.scale = '0;
      1:       r.scale = '1;
      2:       r.scale = SCALE_W'($urandom_range(0, 15));
      default: r.scale = SCALE_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       r.zero_point = ZP_W'(-512);
      1:       r.zero_point = ZP_W'(511);
      default: r.zero_point = ZP_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       r.x_value = X_W'(-32768);
      1:       r.x_value = X_W'(32767);
      default: r.x_value = X_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       r.bias_value = 32'sh8000_0000;
      1:       r.bias_value = 32'sh7FFF_FFFF;
      default: r.bias_value = BIAS_W'($urandom);
    endcase
    r.row_start = s;
    r.row_end   = e;
    return r;
  endfunction

  task automatic send_request(input weight_req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    code_i       <= r.code;
    scale_i      <= r.scale;
    zero_point_i <= r.zero_point;
    x_value_i    <= r.x_value;
    bias_value_i <= r.bias_value;
    row_start_i  <= r.row_start;
    row_end_i    <= r.row_end;
    in_valid_i   <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] val);
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(input logic idx);
    logic [PDATA_W-1:0] mask, want;
    mask = (idx == REG_CODE_BITS) ? PDATA_W'(4'hF) : PDATA_W'(1'b1);
    want = (idx == REG_CODE_BITS) ? PDATA_W'(sb.code_bits) : PDATA_W'(sb.bias_en);
    paddr   <= PADDR_W'({idx, 2'b00});
    pwrite  <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & mask) !== want) begin
      $error("prdata[%0d]: expected %0h, got %0h", idx, want, prdata & mask);
      sb.n_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // rows without an end leave work in flight, so allow the pipeline to empty
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (sb.pending_rows.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [CB_W-1:0] cb, input logic be);
    wait_quiet();
    reg_write(REG_CODE_BITS, ($urandom & ~32'hF) | PDATA_W'(cb));
    reg_write(REG_BIAS_EN, ($urandom & ~32'h1) | PDATA_W'(be));
    reg_check(REG_CODE_BITS);
    reg_check(REG_BIAS_EN);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 71; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 71; end
      default: begin src_idle_pct = 12; snk_stall_pct = 12; end
    endcase
  endtask

  task automatic run_rows(input int unsigned n_items);
    int unsigned sent, len;
    logic        drop_start, drop_end, s, e;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      drop_start = ($urandom_range(0, 9) == 0);
      drop_end   = ($urandom_range(0, 11) == 0);
      for (int k = 0; k < len; k++) begin
        s = (k == 0 && !drop_start) || ($urandom_range(0, 29) == 0);
        e = (k == len - 1) && !drop_end;
        send_request(rand_req(s, e));
        sent++;
      end
    end
  endtask

  logic [CB_W-1:0] phase_cb[8] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'd9, 4'd6, 4'd2};
  logic            phase_be[8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    code_i       = '0;
    scale_i      = '0;
    zero_point_i = '0;
    x_value_i    = '0;
    bias_value_i = '0;
    row_start_i  = 1'b0;
    row_end_i    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    reg_check(REG_CODE_BITS);
    reg_check(REG_BIAS_EN);

    // directed corners at reset settings: 4-bit codes, bias on
    set_idling(0);
    send_request(mk_req(8'hFF, 16'hFFFF, 10'sh200, 16'sd32767, 32'sh7FFF_FFFF, 1'b1, 1'b1));
    send_request(mk_req(8'h00, 16'hFFFF, 10'sd511, 16'sd32767, 32'sh8000_0000, 1'b1, 1'b1));
    send_request(mk_req(8'h0F, 16'h0000, 10'sd0, 16'sh8000, 32'sh1234_5678, 1'b1, 1'b1));
    send_request(mk_req(8'hF1, 16'h0001, 10'sd0, 16'sd2048, 32'sd0, 1'b1, 1'b1));
    send_request(mk_req(8'h01, 16'h0001, 10'sd0, -16'sd2048, 32'sd0, 1'b1, 1'b1));
    send_request(mk_req(8'h01, 16'h0001, 10'sd0, -16'sd2049, 32'sd0, 1'b1, 1'b1));
    // no row start: bias must not be picked up
    send_request(mk_req(8'h03, 16'h1000, 10'sd1, 16'sd4096, 32'sh7FFF_FFFF, 1'b0, 1'b1));
    send_request(mk_req(8'h05, 16'h1000, -10'sd3, 16'sd4096, 32'sd1000, 1'b1, 1'b0));
    send_request(mk_req(8'h0C, 16'h8000, 10'sd7, -16'sd4096, 32'sd0, 1'b0, 1'b0));
    send_request(mk_req(8'h00, 16'hFFFF, 10'sh200, 16'sh8000, 32'sd0, 1'b0, 1'b0));
    send_request(mk_req(8'h0F, 16'h0FFF, 10'sd511, 16'sd32767, 32'sd0, 1'b0, 1'b1));
    // second start inside a row reseeds it
    send_request(mk_req(8'h02, 16'h1000, 10'sd0, 16'sd4096, 32'sd500, 1'b1, 1'b0));
    send_request(mk_req(8'h02, 16'h1000, 10'sd0, 16'sd4096, -32'sd500, 1'b1, 1'b1));
    send_request(mk_req(8'h00, 16'h0000, 10'sd0, 16'sd0, 32'sd0, 1'b1, 1'b1));

    for (int p = 0; p < 8; p++) begin
      set_config(phase_cb[p], phase_be[p]);
      set_idling(p % 4);
      run_rows(225);
    end

    // one long row of maximal terms drives the row sum past the 32-bit range
    set_config(4'd8, 1'b1);
    set_idling(0);
    send_request(mk_req(8'hFF, 16'hFFFF, 10'sh200, 16'sd32767, 32'sh7FFF_FFFF, 1'b1, 1'b0));
    for (int k = 0; k < 39; k++)
      send_request(mk_req(8'hFF, 16'hFFFF, 10'sh200, 16'sd32767, 32'sd0, 1'b0, k == 38));

    wait_quiet();
    repeat (4) @(negedge clk_i);
    $display("Covered %0d requests and %0d row results (%0d clipped) over code widths 0..15,",
             sb.n_requests, sb.n_rows, sb.n_clipped);
    $display("both bias settings, four pacing patterns and a long row clipped to 32 bits.");
    if (sb.n_errors == 0) begin
      $display("lowbit_dequant_gemv_row verification clean");
    end else begin
      $display("lowbit_dequant_gemv_row verification failed");
    end
    $finish;
  end

endmodule
